@@ design/pbs_pkg.sv @@
// Package for the polygon band splitter: word types, edge action table and
// shared constants. Used by every module of the block; depends on nothing.
package pbs_pkg;

  localparam int COORD_W = 32;
  localparam int DIV_NUM_W = 66;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = 7;

  localparam logic [1:0] REG_OFFSET = 2'd0;
  localparam logic [1:0] REG_SLOPE = 2'd1;
  localparam logic [1:0] REG_LIMIT1 = 2'd2;
  localparam logic [1:0] REG_LIMIT2 = 2'd3;

  localparam logic [1:0] ZONE_OUT_LO = 2'd0;
  localparam logic [1:0] ZONE_BAND1 = 2'd1;
  localparam logic [1:0] ZONE_BAND2 = 2'd2;
  localparam logic [1:0] ZONE_OUT_HI = 2'd3;

  typedef struct packed {
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic last_vertex;
  } in_item_t;

  typedef struct packed {
    logic band;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic point_valid;
    logic polygon_done;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_X0 = 3'd1,
    OP_X1 = 3'd2,
    OP_X2 = 3'd3,
    OP_PT = 3'd4
  } op_t;

  typedef struct packed {
    logic b2;
    op_t op;
  } edge_op_t;

  typedef enum logic [1:0] {
    K_PT = 2'd0,
    K_CROSS = 2'd1,
    K_MARK = 2'd2
  } kind_t;

  // One queued job: one result word to be produced by the back end.
  typedef struct packed {
    kind_t kind;
    logic band;
    logic done;
    logic signed [31:0] yj;
    logic signed [31:0] zj;
    logic signed [31:0] yi;
    logic signed [31:0] zi;
    logic signed [31:0] zt;
  } job_t;

  // Actions along an edge, four nibbles {band two, op}, the first in the
  // lowest nibble; a row ends at its first empty nibble.
  function automatic logic [15:0] edge_row(input logic [1:0] from_zone,
                                           input logic [1:0] to_zone);
    logic [15:0] row;
    begin
      case ({from_zone, to_zone})
        4'd1: row = 16'h0041;
        4'd2: row = 16'hCA21;
        4'd3: row = 16'hBA21;
        4'd4: row = 16'h0001;
        4'd5: row = 16'h0004;
        4'd6: row = 16'h0CA2;
        4'd7: row = 16'h0BA2;
        4'd8: row = 16'h012A;
        4'd9: row = 16'h042A;
        4'd10: row = 16'h000C;
        4'd11: row = 16'h000B;
        4'd12: row = 16'h12AB;
        4'd13: row = 16'h42AB;
        4'd14: row = 16'h00CB;
        default: row = 16'h0000;
      endcase
      return row;
    end
  endfunction

  function automatic logic [2:0] row_count(input logic [15:0] row);
    logic [2:0] n;
    begin
      n = 3'd0;
      for (int i = 0; i < 4; i++) begin
        if (row[i*4 +: 4] != 4'h0) n = n + 3'd1;
      end
      return n;
    end
  endfunction

endpackage

@@ design/pbs_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pbs_pkg for its widths.
module pbs_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [pbs_pkg::DIV_NUM_W-1:0] dividend,
  input  logic [pbs_pkg::DIV_DEN_W-1:0] divisor,
  output logic                     done,
  output logic [pbs_pkg::DIV_NUM_W-1:0] quotient
);
  import pbs_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_DEN_W:0]   rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem[DIV_DEN_W-1:0], quotient[DIV_NUM_W-1]};
  assign fits = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && start) begin
        busy <= 1'b1;
        count <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && start) begin
      rem <= '0;
      quotient <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, den} : trial;
      quotient <= {quotient[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

@@ design/pbs_front.sv @@
// Front end: configuration registers, border computation, zone classing and
// job issue into the queue. Depends on pbs_pkg and pbs_div.
module pbs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbs_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output pbs_pkg::job_t     push_data
);
  import pbs_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_BORD = 4'b0010,
    F_CLASS = 4'b0100,
    F_EMIT = 4'b1000
  } fstate_t;

  typedef enum logic [1:0] {
    P_A = 2'd0,
    P_B = 2'd1,
    P_MARK = 2'd2
  } phase_t;

  fstate_t state;
  phase_t  phase;

  logic signed [31:0] strain_offset, strain_slope, first_limit, second_limit;
  logic signed [31:0] thr [3];
  logic               bvalid;
  logic [1:0]         bi;
  logic               bstarted;
  logic               bneg;

  logic signed [31:0] cur_y, cur_z;
  logic               cur_last;
  logic signed [31:0] first_y, first_z, prev_y, prev_z;
  logic [1:0]         first_zone, prev_zone;
  logic               have_first;

  logic signed [31:0] pa_y, pa_z;
  logic [15:0]        row_a, row_b;
  logic [2:0]         cnt_a, cnt_b;
  logic [2:0]         k;
  logic [3:0]         pushed, total;

  logic [1:0]  zn;
  logic        rising, falling;
  logic [15:0] row_a_next, row_b_next;
  logic [1:0]  first_zone_next;

  logic signed [32:0] lim_ext, diff;
  logic [32:0]        diff_mag, slope_mag;
  logic               div_start, div_done;
  logic [DIV_NUM_W-1:0] div_q;
  logic signed [31:0] border_val;

  logic [15:0] row_cur;
  logic [2:0]  cnt_cur;
  edge_op_t    eop;
  logic signed [31:0] zt_sel;

  assign rising = (thr[0] < thr[1]) && (thr[1] < thr[2]);
  assign falling = (thr[0] > thr[1]) && (thr[1] > thr[2]);

  always_comb begin
    zn = ZONE_OUT_LO;
    if (rising) begin
      if (cur_z < thr[0]) zn = ZONE_OUT_LO;
      else if (cur_z < thr[1]) zn = ZONE_BAND1;
      else if (cur_z <= thr[2]) zn = ZONE_BAND2;
      else zn = ZONE_OUT_HI;
    end else if (falling) begin
      if (cur_z < thr[2]) zn = ZONE_OUT_HI;
      else if (cur_z <= thr[1]) zn = ZONE_BAND2;
      else if (cur_z <= thr[0]) zn = ZONE_BAND1;
      else zn = ZONE_OUT_LO;
    end
  end

  // The first vertex of a polygon has no incoming edge; it is emitted alone
  // when it lies in a band.
  always_comb begin
    if (have_first) begin
      row_a_next = edge_row(prev_zone, zn);
      first_zone_next = first_zone;
    end else begin
      first_zone_next = zn;
      if (zn == ZONE_BAND1) row_a_next = 16'h0004;
      else if (zn == ZONE_BAND2) row_a_next = 16'h000C;
      else row_a_next = 16'h0000;
    end
    row_b_next = edge_row(zn, first_zone_next);
  end

  // Border numerator (limit - offset) * 2^16 divided in magnitude.
  always_comb begin
    case (bi)
      2'd1: lim_ext = {first_limit[31], first_limit};
      2'd2: lim_ext = {second_limit[31], second_limit};
      default: lim_ext = '0;
    endcase
    diff = lim_ext - {strain_offset[31], strain_offset};
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    slope_mag = strain_slope[31] ? 33'(-{1'b1, strain_slope}) : {1'b0, strain_slope};
  end

  // Truncated signed quotient saturated to 32 bits.
  always_comb begin
    if (!bneg) begin
      border_val = (div_q[DIV_NUM_W-1:31] != '0) ? 32'sh7FFFFFFF : $signed(div_q[31:0]);
    end else begin
      if ((div_q[DIV_NUM_W-1:32] != '0) || (div_q[31] && (div_q[30:0] != '0)))
        border_val = 32'sh80000000;
      else
        border_val = $signed(-div_q[31:0]);
    end
  end

  assign div_start = (state == F_BORD) && (strain_slope != '0) && !bstarted;

  pbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({17'b0, diff_mag, 16'b0}),
    .divisor  (slope_mag),
    .done     (div_done),
    .quotient (div_q)
  );

  assign cfg_ready = (state == F_IDLE);
  assign in_ready = (state == F_IDLE) && bvalid && !cfg_valid;

  assign row_cur = (phase == P_A) ? row_a : row_b;
  assign cnt_cur = (phase == P_A) ? cnt_a : (cur_last ? cnt_b : 3'd0);
  assign eop = edge_op_t'(row_cur[k[1:0]*4 +: 4]);

  always_comb begin
    case (eop.op)
      OP_X0: zt_sel = thr[0];
      OP_X1: zt_sel = thr[1];
      OP_X2: zt_sel = thr[2];
      default: zt_sel = '0;
    endcase
  end

  always_comb begin
    push_valid = 1'b0;
    push_data = '0;
    push_data.kind = K_MARK;
    if (state == F_EMIT) begin
      if (phase == P_MARK) begin
        push_valid = 1'b1;
        push_data.done = 1'b1;
      end else if (k < cnt_cur) begin
        push_valid = 1'b1;
        push_data.kind = (eop.op == OP_PT) ? K_PT : K_CROSS;
        push_data.band = eop.b2;
        push_data.done = cur_last && ((pushed + 4'd1) == total);
        push_data.zt = zt_sel;
        if (phase == P_A) begin
          push_data.yj = pa_y;
          push_data.zj = pa_z;
          push_data.yi = cur_y;
          push_data.zi = cur_z;
        end else begin
          push_data.yj = cur_y;
          push_data.zj = cur_z;
          push_data.yi = first_y;
          push_data.zi = first_z;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      phase <= P_A;
      strain_offset <= '0;
      strain_slope <= '0;
      first_limit <= '0;
      second_limit <= '0;
      bvalid <= 1'b0;
      bi <= '0;
      bstarted <= 1'b0;
      have_first <= 1'b0;
      first_y <= '0;
      first_z <= '0;
      first_zone <= '0;
      prev_y <= '0;
      prev_z <= '0;
      prev_zone <= '0;
      k <= '0;
      pushed <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (cfg_valid) begin
            bvalid <= 1'b0;
            case (cfg_index)
              REG_OFFSET: strain_offset <= cfg_data;
              REG_SLOPE: strain_slope <= cfg_data;
              REG_LIMIT1: first_limit <= cfg_data;
              default: second_limit <= cfg_data;
            endcase
          end else if (!bvalid) begin
            state <= F_BORD;
            bi <= '0;
            bstarted <= 1'b0;
          end else if (in_valid) begin
            state <= F_CLASS;
          end
        end
        F_BORD: begin
          if (strain_slope == '0) begin
            bvalid <= 1'b1;
            state <= F_IDLE;
          end else if (!bstarted) begin
            bstarted <= 1'b1;
            bneg <= diff[32] ^ strain_slope[31];
          end else if (div_done) begin
            bstarted <= 1'b0;
            if (bi == 2'd2) begin
              bvalid <= 1'b1;
              state <= F_IDLE;
            end else begin
              bi <= bi + 2'd1;
            end
          end
        end
        F_CLASS: begin
          pa_y <= prev_y;
          pa_z <= prev_z;
          row_a <= row_a_next;
          row_b <= row_b_next;
          cnt_a <= row_count(row_a_next);
          cnt_b <= row_count(row_b_next);
          total <= {1'b0, row_count(row_a_next)}
                   + (cur_last ? {1'b0, row_count(row_b_next)} : 4'd0);
          prev_y <= cur_y;
          prev_z <= cur_z;
          prev_zone <= zn;
          if (!have_first) begin
            first_y <= cur_y;
            first_z <= cur_z;
            first_zone <= zn;
          end
          have_first <= !cur_last;
          phase <= P_A;
          k <= '0;
          pushed <= '0;
          state <= F_EMIT;
        end
        F_EMIT: begin
          if (phase == P_MARK) begin
            if (push_ready) state <= F_IDLE;
          end else if (k < cnt_cur) begin
            if (push_ready) begin
              k <= k + 3'd1;
              pushed <= pushed + 4'd1;
            end
          end else if (phase == P_A) begin
            phase <= P_B;
            k <= '0;
          end else if (cur_last && (total == 4'd0)) begin
            phase <= P_MARK;
          end else begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && in_ready && in_valid) begin
      cur_y <= in_data.vertex_y;
      cur_z <= in_data.vertex_z;
      cur_last <= in_data.last_vertex;
    end
    if (rst) begin
      thr[0] <= '0;
      thr[1] <= '0;
      thr[2] <= '0;
    end else if (state == F_BORD) begin
      if (strain_slope == '0) begin
        thr[0] <= '0;
        thr[1] <= '0;
        thr[2] <= '0;
      end else if (bstarted && div_done) begin
        thr[bi] <= border_val;
      end
    end
  end

endmodule

@@ design/pbs_queue.sv @@
// Small job queue between front and back end.
// Depends on pbs_pkg for the job word.
module pbs_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pbs_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pbs_pkg::job_t pop_data
);
  import pbs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_data = slots[head];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      if (do_pop) head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[tail] <= push_data;
  end

endmodule

@@ design/pbs_back.sv @@
// Back end: turns queued jobs into result words, interpolating crossings
// with a split multiply and a serial divide. Depends on pbs_pkg and pbs_div.
module pbs_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  pbs_pkg::job_t      pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbs_pkg::out_item_t out_data
);
  import pbs_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_PREP = 7'b0000010,
    B_MUL0 = 7'b0000100,
    B_MUL1 = 7'b0001000,
    B_DSTART = 7'b0010000,
    B_WAIT = 7'b0100000,
    B_FIN = 7'b1000000
  } bstate_t;

  bstate_t state;
  job_t    job;

  logic [32:0]          a, b, c;
  logic                 neg, dzero;
  logic [49:0]          p0;
  logic [DIV_NUM_W-1:0] prod;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_q;

  logic signed [32:0] dy, dn, dd;
  logic [49:0]        mul_lo;
  logic [48:0]        mul_hi;
  out_item_t          res;

  assign dy = {job.yi[31], job.yi} - {job.yj[31], job.yj};
  assign dn = {job.zt[31], job.zt} - {job.zj[31], job.zj};
  assign dd = {job.zi[31], job.zi} - {job.zj[31], job.zj};
  assign mul_lo = a * b[16:0];
  assign mul_hi = a * b[32:17];

  assign pop_ready = (state == B_IDLE);

  pbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == B_DSTART),
    .dividend (prod),
    .divisor  (c),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    res.band = job.band;
    res.polygon_done = job.done;
    res.point_valid = (job.kind != K_MARK);
    case (job.kind)
      K_PT: begin
        res.point_y = job.yi;
        res.point_z = job.zi;
      end
      K_CROSS: begin
        res.point_z = job.zt;
        if (dzero) res.point_y = job.yj;
        else if (neg) res.point_y = job.yj - $signed(div_q[31:0]);
        else res.point_y = job.yj + $signed(div_q[31:0]);
      end
      default: begin
        res.point_y = '0;
        res.point_z = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == B_FIN && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (pop_valid) state <= (pop_data.kind == K_CROSS) ? B_PREP : B_FIN;
        end
        B_PREP: state <= (dd == '0) ? B_FIN : B_MUL0;
        B_MUL0: state <= B_MUL1;
        B_MUL1: state <= B_DSTART;
        B_DSTART: state <= B_WAIT;
        B_WAIT: begin
          if (div_done) state <= B_FIN;
        end
        B_FIN: begin
          if (!out_valid || out_ready) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      job <= pop_data;
      dzero <= 1'b0;
    end
    if (state == B_PREP) begin
      a <= dy[32] ? 33'(-dy) : 33'(dy);
      b <= dn[32] ? 33'(-dn) : 33'(dn);
      c <= dd[32] ? 33'(-dd) : 33'(dd);
      neg <= dy[32] ^ dn[32] ^ dd[32];
      dzero <= (dd == '0);
    end
    if (state == B_MUL0) p0 <= mul_lo;
    if (state == B_MUL1) prod <= {16'b0, p0} + {mul_hi, 17'b0};
    if (state == B_FIN && (!out_valid || out_ready)) out_data <= res;
  end

endmodule

@@ design/polygon_band_splitter_top.sv @@
// Channel   Direction  Word                 Handshake
// cfg       in         cfg_index, cfg_data  cfg_valid / cfg_ready
// in        in         in_item_t            in_valid / in_ready
// out       out        out_item_t           out_valid / out_ready
//
// A vertex passes the front end's idle, classify and emit states, the last
// issuing its jobs one by one and an end marker if a polygon's last vertex
// issues none. Back-end crossing points use the one-bit-per-cycle 66-bit
// divider unless the edge is flat in z. After reset or any configuration
// write the first vertex waits for the border recompute, three serial divides
// (none if the slope is zero). Reset is synchronous; the queue lets the front
// classify while the back end divides or a stalled consumer holds the output.
module polygon_band_splitter_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  pbs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pbs_pkg::out_item_t out_data
);
  import pbs_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_data, pop_data;

  pbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
